FILE: src/ham_planar_pixel_decoder_assert.svh
// Assertion macros used by the port-level checker of the HAM planar pixel decoder.
`ifndef HAM_PLANAR_PIXEL_DECODER_ASSERT_SVH
`define HAM_PLANAR_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define HPPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("hppd assertion failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define HPPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("hppd assertion failed");

`endif

FILE: src/hppd_pkg.sv
// Shared types and constants of the HAM planar pixel decoder.
`default_nettype none

package hppd_pkg;

  // Palette store depth and address width.
  localparam int PAL_ENTRIES = 64;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_COLOR_MODE = 1'b0;

  // Color modes; the unused code decodes as direct.
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_HAM6   = 2'd1;
  localparam logic [1:0] MODE_HAM8   = 2'd2;

  // Item kinds.
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  // HAM control codes.
  typedef enum logic [1:0] {
    CODE_LOAD  = 2'd0,
    CODE_BLUE  = 2'd1,
    CODE_RED   = 2'd2,
    CODE_GREEN = 2'd3
  } ham_code_t;

endpackage

`default_nettype wire

FILE: src/ham_planar_pixel_decoder.sv
// Top level of the HAM planar pixel decoder: palette store, held color and output register.
//
// One input item is taken every clock cycle while the result side keeps up. A palette
// write is done at its transfer and gives no result. A pixel gives one RGB result: the
// transfer edge registers the pixel together with the synchronous read of the palette
// store, and when the pixel stage moves on, the HAM update is applied to the held color
// and the output register is loaded. The single palette read port sits in the first
// stage and the held-color update in the second, so the block sustains one item per
// cycle while the result side keeps up. A stalled result holds the pipeline once the
// pixel stage behind it is full. There is no clearing pass; palette entries read
// before being written give undefined colors.
`default_nettype none

module ham_planar_pixel_decoder
  import hppd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [5:0]        in_palette_index,
  input  wire logic [23:0]       in_palette_color,
  input  wire logic [23:0]       in_plane_bits,
  input  wire logic              in_row_start,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_red,
  output logic      [7:0]        out_green,
  output logic      [7:0]        out_blue
);

  logic [1:0]  color_mode_r;

  logic [23:0] pal_mem [PAL_ENTRIES];
  logic [23:0] pal_rd_r;
  logic        pal_oor_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic [23:0] s1_planes_r;
  logic        s1_row_start_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;
  logic [7:0]  held_red_r, held_green_r, held_blue_r;
  logic [7:0]  held_red_nxt, held_green_nxt, held_blue_nxt;
  logic [7:0]  res_red, res_green, res_blue;

  logic        in_fire, pal_we, ld_en, s1_go, cfg_we;
  logic [5:0]  ld_idx;
  logic        ld_oor;

  logic        mode_ham6, mode_ham8;
  logic [7:0]  base_red, base_green, base_blue;
  logic [23:0] pal_color;
  ham_code_t   code;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = {{(CFG_DW-2){1'b0}}, color_mode_r};
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_COLOR_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_DIRECT;
    end else if (cfg_we) begin
      color_mode_r <= pwdata[1:0];
    end
  end

  assign mode_ham6 = (color_mode_r == MODE_HAM6);
  assign mode_ham8 = (color_mode_r == MODE_HAM8);

  // ---------------------------------------------------------------- stage 1
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;
  assign pal_we   = in_fire && (in_kind == KIND_PALETTE)
                    && ({1'b0, in_palette_index} < 7'(PAL_ENTRIES));
  assign ld_en    = in_fire && (in_kind == KIND_PIXEL);

  // Palette load index; HAM6 uses only the low four data planes.
  assign ld_idx = mode_ham6 ? {2'b00, in_plane_bits[3:0]} : in_plane_bits[5:0];
  assign ld_oor = ({1'b0, ld_idx} >= 7'(PAL_ENTRIES));

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[in_palette_index[PAL_AW-1:0]] <= in_palette_color;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      pal_rd_r       <= pal_mem[ld_idx[PAL_AW-1:0]];
      pal_oor_r      <= ld_oor;
      s1_planes_r    <= in_plane_bits;
      s1_row_start_r <= in_row_start;
    end
  end

  assign s1_valid_nxt = ld_en ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    // A row start clears the held color in every mode, before the update.
    base_red   = s1_row_start_r ? 8'h00 : held_red_r;
    base_green = s1_row_start_r ? 8'h00 : held_green_r;
    base_blue  = s1_row_start_r ? 8'h00 : held_blue_r;
    pal_color  = pal_oor_r ? 24'h000000 : pal_rd_r;
    code       = mode_ham6 ? ham_code_t'(s1_planes_r[5:4]) : ham_code_t'(s1_planes_r[7:6]);

    held_red_nxt   = base_red;
    held_green_nxt = base_green;
    held_blue_nxt  = base_blue;

    if (mode_ham6 || mode_ham8) begin
      case (code)
        CODE_LOAD: begin
          held_red_nxt   = pal_color[23:16];
          held_green_nxt = pal_color[15:8];
          held_blue_nxt  = pal_color[7:0];
        end
        CODE_BLUE: begin
          held_blue_nxt = mode_ham6 ? {s1_planes_r[3:0], s1_planes_r[3:0]}
                                    : {s1_planes_r[5:0], base_blue[1:0]};
        end
        CODE_RED: begin
          held_red_nxt = mode_ham6 ? {s1_planes_r[3:0], s1_planes_r[3:0]}
                                   : {s1_planes_r[5:0], base_red[1:0]};
        end
        default: begin
          held_green_nxt = mode_ham6 ? {s1_planes_r[3:0], s1_planes_r[3:0]}
                                     : {s1_planes_r[5:0], base_green[1:0]};
        end
      endcase
      res_red   = held_red_nxt;
      res_green = held_green_nxt;
      res_blue  = held_blue_nxt;
    end else begin
      res_red   = s1_planes_r[7:0];
      res_green = s1_planes_r[15:8];
      res_blue  = s1_planes_r[23:16];
    end
  end

  assign out_valid_nxt = s1_go ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_red_r   <= 8'h00;
      held_green_r <= 8'h00;
      held_blue_r  <= 8'h00;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        held_red_r   <= held_red_nxt;
        held_green_r <= held_green_nxt;
        held_blue_r  <= held_blue_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_red_r   <= res_red;
      out_green_r <= res_green;
      out_blue_r  <= res_blue;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

`default_nettype wire

FILE: src/hppd_checker.sv
// Port-level assertion checker of the HAM planar pixel decoder and its bind.
`default_nettype none

`include "ham_planar_pixel_decoder_assert.svh"

module hppd_checker
  import hppd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [CFG_AW-1:0] paddr,
  input wire logic [CFG_DW-1:0] pwdata,
  input wire logic [CFG_DW-1:0] prdata,
  input wire logic              pready,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_kind,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [7:0]        out_red,
  input wire logic [7:0]        out_green,
  input wire logic [7:0]        out_blue
);

  // A stalled result stays put.
  `HPPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))

  // The input side only backs up behind a stalled result.
  `HPPD_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)

  // A pixel transfer has a result waiting once it has passed the pixel stage into the output register.
  `HPPD_ASSERT_IMPL(a_pixel_result, in_valid && in_ready && (in_kind == KIND_PIXEL),
                    ##2 out_valid)

  // A write of the mode register reads back on the next cycle.
  `HPPD_ASSERT_NEXT(a_cfg_readback,
                    psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_MODE),
                    (prdata[1:0] == $past(pwdata[1:0])) && (prdata[CFG_DW-1:2] == '0))

endmodule

bind ham_planar_pixel_decoder hppd_checker u_hppd_checker (.*);

`default_nettype wire

FILE: bench/ham_planar_pixel_decoder_tb.sv
// Self-checking testbench for the HAM planar pixel decoder: directed and random traffic against a predictor.
module ham_planar_pixel_decoder_tb
  import hppd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The register allows a fourth mode value, which decodes like direct mode.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_COLOR_MODE = CFG_AW'(4 * REG_COLOR_MODE);
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic        kind;
    logic [5:0]  pal_idx;
    logic [23:0] pal_color;
    logic [23:0] planes;
    logic        row_start;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [5:0]  in_palette_index = '0;
  logic [23:0] in_palette_color = '0;
  logic [23:0] in_plane_bits = '0;
  logic        in_row_start = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // Stimulus waiting to be sent and decoded colors waiting to come out.
  item_t item_feed[$];
  rgb_t  rgb_due[$];

  // Predictor state.
  logic [23:0] pal_mem[PAL_ENTRIES];
  logic [7:0]  hold_r = '0;
  logic [7:0]  hold_g = '0;
  logic [7:0]  hold_b = '0;
  logic [1:0]  cur_mode = MODE_DIRECT;

  // Entries the generator has already scheduled a write for.
  bit pal_known[PAL_ENTRIES];

  int err_count = 0;
  int pixels_checked = 0;
  int pal_writes_sent = 0;
  int mode_settings = 0;

  item_t cur_item;
  int    src_gap = 0;
  int    src_burst = 0;
  int    snk_stall = 0;
  int    snk_burst = 0;

  ham_planar_pixel_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_palette_index (in_palette_index),
    .in_palette_color (in_palette_color),
    .in_plane_bits    (in_plane_bits),
    .in_row_start     (in_row_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a run with no gaps at all.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t mk_item(logic kind, logic [5:0] idx, logic [23:0] color,
                                    logic [23:0] planes, logic row_start);
    item_t it;
    it.kind = kind;
    it.pal_idx = idx;
    it.pal_color = color;
    it.planes = planes;
    it.row_start = row_start;
    return it;
  endfunction

  // Applies one accepted item to the predictor and queues the color it must produce.
  task automatic ham_decode(input item_t it);
    ham_code_t   code;
    logic [5:0]  data;
    logic [7:0]  val;
    logic [7:0]  keep;
    logic [23:0] c;
    if (it.kind == KIND_PALETTE) begin
      if (it.pal_idx < PAL_ENTRIES) pal_mem[it.pal_idx] = it.pal_color;
      return;
    end
    if (it.row_start) begin
      hold_r = '0;
      hold_g = '0;
      hold_b = '0;
    end
    if (cur_mode == MODE_HAM6 || cur_mode == MODE_HAM8) begin
      if (cur_mode == MODE_HAM6) begin
        code = ham_code_t'(it.planes[5:4]);
        data = {2'b00, it.planes[3:0]};
        val  = {it.planes[3:0], it.planes[3:0]};
        keep = 8'h00;
      end else begin
        code = ham_code_t'(it.planes[7:6]);
        data = it.planes[5:0];
        val  = {it.planes[5:0], 2'b00};
        keep = 8'h03;
      end
      case (code)
        CODE_LOAD: begin
          c = (data < PAL_ENTRIES) ? pal_mem[data] : 24'h0;
          hold_r = c[23:16];
          hold_g = c[15:8];
          hold_b = c[7:0];
        end
        CODE_BLUE:  hold_b = (val & ~keep) | (hold_b & keep);
        CODE_RED:   hold_r = (val & ~keep) | (hold_r & keep);
        default:    hold_g = (val & ~keep) | (hold_g & keep);
      endcase
      rgb_due.push_back('{red: hold_r, green: hold_g, blue: hold_b});
    end else begin
      rgb_due.push_back('{red: it.planes[7:0], green: it.planes[15:8], blue: it.planes[23:16]});
    end
  endtask

  task automatic push_item(input item_t it);
    if (it.kind == KIND_PALETTE) pal_known[it.pal_idx] = 1'b1;
    item_feed.push_back(it);
  endtask

  // Random items for the current mode; a palette load is always preceded by a write of its entry.
  task automatic queue_random(input int count);
    item_t      it;
    item_t      ld_it;
    logic [5:0] ld;
    bit         is_load;
    for (int i = 0; i < count; i++) begin
      it = mk_item(KIND_PIXEL, 6'($urandom), 24'($urandom), 24'($urandom),
                   $urandom_range(0, 15) == 0);
      if ($urandom_range(0, 99) < 15) begin
        it.kind = KIND_PALETTE;
        if (cur_mode == MODE_HAM6 && $urandom_range(0, 1) == 1) it.pal_idx[5:4] = 2'b00;
        push_item(it);
        // Sometimes read the entry back right after writing it.
        if ($urandom_range(0, 3) == 0) begin
          ld_it = mk_item(KIND_PIXEL, 6'($urandom), 24'($urandom), 24'($urandom), 1'b0);
          if (cur_mode == MODE_HAM6 && it.pal_idx < 16) begin
            ld_it.planes[5:0] = {2'b00, it.pal_idx[3:0]};
            push_item(ld_it);
          end else if (cur_mode == MODE_HAM8) begin
            ld_it.planes[7:0] = {2'b00, it.pal_idx};
            push_item(ld_it);
          end
        end
      end else begin
        is_load = 1'b0;
        ld = '0;
        if (cur_mode == MODE_HAM6 && it.planes[5:4] == CODE_LOAD) begin
          is_load = 1'b1;
          ld = {2'b00, it.planes[3:0]};
        end else if (cur_mode == MODE_HAM8 && it.planes[7:6] == CODE_LOAD) begin
          is_load = 1'b1;
          ld = it.planes[5:0];
        end
        if (is_load && !pal_known[ld])
          push_item(mk_item(KIND_PALETTE, ld, 24'($urandom), 24'($urandom),
                            1'($urandom)));
        push_item(it);
      end
    end
  endtask

  // Waits until every queued item has been sent and every decoded color has come out.
  // The check runs at the falling edge so that the driver's updates have all settled.
  task automatic drain;
    do @(negedge clk);
    while (item_feed.size() != 0 || in_valid || rgb_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_mode(input logic [1:0] mode);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b1, ADDR_COLOR_MODE, CFG_DW'(mode), rd);
    cur_mode = mode;
    mode_settings++;
    cfg_access(1'b0, ADDR_COLOR_MODE, '0, rd);
    if (rd !== CFG_DW'(mode)) begin
      $error("color_mode readback: expected %0h, actual %0h", mode, rd);
      err_count++;
    end
  endtask

  // Input side: one item per transfer, with random gaps between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        ham_decode(cur_item);
        if (cur_item.kind == KIND_PALETTE) pal_writes_sent++;
      end
      if (in_valid && !in_ready) begin
        // Hold the item until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (item_feed.size() > 0) begin
        cur_item = item_feed.pop_front();
        in_kind          <= cur_item.kind;
        in_palette_index <= cur_item.pal_idx;
        in_palette_color <= cur_item.pal_color;
        in_plane_bits    <= cur_item.planes;
        in_row_start     <= cur_item.row_start;
        in_valid         <= 1'b1;
        src_gap = pick_gap(src_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure and a field-by-field check of each transfer.
  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          $error("result with nothing expected: red %0h green %0h blue %0h",
                 out_red, out_green, out_blue);
          err_count++;
        end else begin
          exp_rgb = rgb_due.pop_front();
          pixels_checked++;
          if (out_red !== exp_rgb.red) begin
            $error("red: expected %0h, actual %0h", exp_rgb.red, out_red);
            err_count++;
          end
          if (out_green !== exp_rgb.green) begin
            $error("green: expected %0h, actual %0h", exp_rgb.green, out_green);
            err_count++;
          end
          if (out_blue !== exp_rgb.blue) begin
            $error("blue: expected %0h, actual %0h", exp_rgb.blue, out_blue);
            err_count++;
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        snk_stall = pick_gap(snk_burst);
      end
    end
  end

  initial begin
    logic [1:0] phase_modes[8];
    phase_modes = '{MODE_HAM6, MODE_HAM8, MODE_DIRECT, MODE_HAM8,
                    MODE_HAM6, MODE_UNUSED, MODE_HAM8, MODE_HAM6};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Direct mode: extreme plane patterns and palette writes at both ends of the store.
    set_mode(MODE_DIRECT);
    push_item(mk_item(KIND_PALETTE, 6'd0, 24'h000000, 24'hffffff, 1'b0));
    push_item(mk_item(KIND_PALETTE, 6'd63, 24'hffffff, 24'h000000, 1'b0));
    push_item(mk_item(KIND_PALETTE, 6'd15, 24'h123456, 24'h000000, 1'b1));
    push_item(mk_item(KIND_PALETTE, 6'd1, 24'hc3a55a, 24'h000000, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h000000, 24'h000000, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd63, 24'hffffff, 24'hffffff, 1'b1));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h000000, 24'h800000, 1'b0));
    drain();

    // HAM6: load, each modify code, and ignored upper planes.
    set_mode(MODE_HAM6);
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h000000, 1'b1));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h00001f, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h000020, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h00003a, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'hffffcf, 1'b0));
    drain();

    // HAM8: held color carried over from HAM6, low-bit keep, and a row start before a modify.
    set_mode(MODE_HAM8);
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h00007f, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h00003f, 1'b1));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h000080, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'hffffd5, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'hffff00, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h000055, 1'b1));
    drain();

    // The unused mode value behaves as direct mode.
    set_mode(MODE_UNUSED);
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'ha5c3ff, 1'b0));
    push_item(mk_item(KIND_PIXEL, 6'd0, 24'h0, 24'h5a3c00, 1'b1));
    drain();

    // Random phases; each one stops halfway until every result is out.
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      queue_random(80);
      drain();
      queue_random(85);
      drain();
    end

    $display("Checked %0d pixel results; %0d palette writes sent; %0d mode settings applied.",
             pixels_checked, pal_writes_sent, mode_settings);
    $display("Modes covered: direct, HAM6, HAM8 and the unused code, with random stalls.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
